// ===== hw/rtl/tcpw_pkg.sv =====
`default_nettype none

package tcpw_pkg;

  // geometry defaults
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 192;
  localparam int TILE           = 8;

  // command codes on the func port
  localparam logic [2:0] FUNC_SET   = 3'd0;
  localparam logic [2:0] FUNC_HLINE = 3'd1;
  localparam logic [2:0] FUNC_VLINE = 3'd2;
  localparam logic [2:0] FUNC_CLEAR = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  // configuration register indexes
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 6;
  localparam logic [CFG_IW-1:0] CFG_FOUR_BIT = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_WIDTH    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT   = 2'd2;

  localparam logic [5:0] RST_WIDTH_TILES  = 6'd32;
  localparam logic [4:0] RST_HEIGHT_TILES = 5'd24;

  localparam logic [7:0] NIB_LO = 8'h0F;
  localparam logic [7:0] NIB_HI = 8'hF0;

  // depth of the command queue between front and back
  localparam int QDEPTH = 2;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_RUN,
    OP_CLEAR,
    OP_READ
  } op_t;

  // one classified command word
  typedef struct packed {
    op_t         op;
    logic        horiz;   // run walks along x
    logic [7:0]  fixed;   // coordinate that stays put during a run
    logic [7:0]  start;
    logic [8:0]  stop;    // exclusive end of the run
    byte_t       color;   // byte, nibble or fill byte depending on op and mode
    logic [15:0] roff;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RUN,
    B_RMW,
    B_CLEAR,
    B_READ,
    B_RDATA,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tiled_canvas_pixel_writer.sv =====
// Set pixel and runs write each pixel directly in 8-bit mode, by read-modify-write in 4-bit mode.
// Clear writes one used byte per cycle; read byte fetches one store byte.
// One command at a time on the single store port; a 2-word queue in front
// accepts while the back end works.
// Reset clears control and config only; store contents stay undefined until written.
`default_nettype none

module tiled_canvas_pixel_writer
  import tcpw_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [2:0]        func,
  input  wire logic [7:0]        x_coord,
  input  wire logic [7:0]        y_coord,
  input  wire logic [7:0]        end_coord,
  input  wire logic [7:0]        color,
  input  wire logic [15:0]       read_offset,
  output logic                   empty,
  input  wire logic              pop,
  output logic [7:0]             read_data,
  output logic                   clipped,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);

  logic       four_bit_mode;
  logic [5:0] width_tiles;
  logic [4:0] height_tiles;
  logic       cmd_valid;
  cmd_t       cmd_head;
  logic       cmd_pop;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode <= 1'b0;
      width_tiles   <= RST_WIDTH_TILES;
      height_tiles  <= RST_HEIGHT_TILES;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FOUR_BIT: four_bit_mode <= cfg_data[0];
        CFG_WIDTH:    width_tiles   <= cfg_data[5:0];
        CFG_HEIGHT:   height_tiles  <= cfg_data[4:0];
        default:      four_bit_mode <= four_bit_mode;
      endcase
    end
  end

  tcpw_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .four_bit_mode (four_bit_mode),
    .func          (func),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .end_coord     (end_coord),
    .color         (color),
    .read_offset   (read_offset),
    .cmd_valid     (cmd_valid),
    .cmd_head      (cmd_head),
    .cmd_pop       (cmd_pop)
  );

  tcpw_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .four_bit_mode (four_bit_mode),
    .width_tiles   (width_tiles),
    .height_tiles  (height_tiles),
    .cmd_valid     (cmd_valid),
    .cmd_head      (cmd_head),
    .cmd_pop       (cmd_pop),
    .empty         (empty),
    .pop           (pop),
    .read_data     (read_data),
    .clipped       (clipped)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tcpw_ram.sv =====
`default_nettype none

module tcpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 49152
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcpw_front.sv =====
`default_nettype none

module tcpw_front
  import tcpw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        four_bit_mode,
  input  wire logic [2:0]  func,
  input  wire logic [7:0]  x_coord,
  input  wire logic [7:0]  y_coord,
  input  wire logic [7:0]  end_coord,
  input  wire logic [7:0]  color,
  input  wire logic [15:0] read_offset,
  output logic             cmd_valid,
  output cmd_t             cmd_head,
  input  wire logic        cmd_pop
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t           q [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QCW-1:0] count;
  cmd_t           cls;
  logic           q_push;

  // classify the incoming word
  always_comb begin
    cls       = '0;
    cls.fixed = y_coord;
    cls.start = x_coord;
    cls.horiz = 1'b1;
    cls.roff  = read_offset;
    cls.color = four_bit_mode ? (color & NIB_LO) : color;
    case (func)
      FUNC_SET: begin
        cls.op   = OP_RUN;
        cls.stop = {1'b0, x_coord} + 9'd1;
      end
      FUNC_HLINE: begin
        cls.op   = OP_RUN;
        cls.stop = {1'b0, end_coord};
      end
      FUNC_VLINE: begin
        cls.op    = OP_RUN;
        cls.horiz = 1'b0;
        cls.fixed = x_coord;
        cls.start = y_coord;
        cls.stop  = {1'b0, end_coord};
      end
      FUNC_CLEAR: begin
        cls.op    = OP_CLEAR;
        cls.color = four_bit_mode ? {color[3:0], color[3:0]} : color;
      end
      FUNC_READ: begin
        cls.op = OP_READ;
      end
      default: begin
        cls.op = OP_NOP;
      end
    endcase
  end

  assign full      = (count == QCW'(QDEPTH));
  assign q_push    = push && !full;
  assign cmd_valid = (count != '0);
  assign cmd_head  = q[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (q_push) begin
      q[wptr] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (q_push) begin
        wptr <= (wptr == QAW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (cmd_pop) begin
        rptr <= (rptr == QAW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({q_push, cmd_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("command queue overfilled");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("pop from empty command queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (q_push && !cmd_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");

endmodule

`default_nettype wire

// ===== hw/rtl/tcpw_back.sv =====
`default_nettype none

module tcpw_back
  import tcpw_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       four_bit_mode,
  input  wire logic [5:0] width_tiles,
  input  wire logic [4:0] height_tiles,
  input  wire logic       cmd_valid,
  input  wire cmd_t       cmd_head,
  output logic            cmd_pop,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      read_data,
  output logic            clipped
);

  localparam int TW_MAX = MAX_WIDTH / TILE;
  localparam int TH_MAX = MAX_HEIGHT / TILE;
  localparam int STORE  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(STORE);
  localparam int UW     = $clog2(STORE + 1);
  localparam int TWW    = $clog2(TW_MAX + 1);
  localparam int THW    = $clog2(TH_MAX + 1);
  localparam int OFW    = AW + 1;

  back_state_t     state, state_next;
  cmd_t            cmd;
  logic [8:0]      pos;
  logic [8:0]      pos_inc;
  logic [UW-1:0]   caddr;
  logic [UW-1:0]   caddr_inc;
  logic            clip_acc;
  byte_t           rdata_acc;
  logic            out_valid;

  logic [TWW-1:0]  tw;
  logic [THW-1:0]  th;
  logic [UW-1:0]   used;

  logic [7:0]      px, py;
  logic            in_area;
  logic            run_last;
  logic            rd_in_range;
  logic [OFW-1:0]  tile_idx;
  logic [OFW-1:0]  off;
  logic [AW-1:0]   pix_addr;
  logic            res_load;

  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  byte_t           ram_wdata;
  byte_t           ram_rdata;

  // clamped geometry, refreshed every cycle from the config registers
  always_ff @(posedge clk) begin
    if (width_tiles == '0) begin
      tw <= TWW'(1);
    end else if (width_tiles > 6'(TW_MAX)) begin
      tw <= TWW'(TW_MAX);
    end else begin
      tw <= TWW'(width_tiles);
    end
    if (height_tiles == '0) begin
      th <= THW'(1);
    end else if ({1'b0, height_tiles} > 6'(TH_MAX)) begin
      th <= THW'(TH_MAX);
    end else begin
      th <= THW'(height_tiles);
    end
    if (four_bit_mode) begin
      used <= UW'(UW'(tw) * UW'(th)) << 5;
    end else begin
      used <= UW'(UW'(tw) * UW'(th)) << 6;
    end
  end

  // current pixel and its tiled address
  assign px        = cmd.horiz ? pos[7:0] : cmd.fixed;
  assign py        = cmd.horiz ? cmd.fixed : pos[7:0];
  assign pos_inc   = pos + 9'd1;
  assign run_last  = (pos_inc >= cmd.stop);
  assign caddr_inc = caddr + 1'b1;
  assign in_area   = (10'(px) < 10'({tw, 3'b000})) && (10'(py) < 10'({th, 3'b000}));
  assign tile_idx  = OFW'(py[7:3]) * OFW'(tw) + OFW'(px[7:3]);
  assign off       = (tile_idx << 6) | OFW'({py[2:0], px[2:0]});
  assign pix_addr  = four_bit_mode ? off[AW:1] : off[AW-1:0];
  assign rd_in_range = (32'(cmd.roff) < 32'(used));

  assign cmd_pop  = (state == B_IDLE) && cmd_valid;
  assign res_load = (state == B_DONE) && (!out_valid || pop);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          case (cmd_head.op)
            OP_RUN:   state_next = ({1'b0, cmd_head.start} >= cmd_head.stop) ? B_DONE : B_RUN;
            OP_CLEAR: state_next = B_CLEAR;
            OP_READ:  state_next = B_READ;
            default:  state_next = B_DONE;
          endcase
        end
      end
      B_RUN: begin
        if (in_area && four_bit_mode) begin
          state_next = B_RMW;
        end else if (run_last) begin
          state_next = B_DONE;
        end
      end
      B_RMW:   state_next = run_last ? B_DONE : B_RUN;
      B_CLEAR: state_next = (caddr_inc >= used) ? B_DONE : B_CLEAR;
      B_READ:  state_next = rd_in_range ? B_RDATA : B_DONE;
      B_RDATA: state_next = B_DONE;
      B_DONE:  state_next = res_load ? B_IDLE : B_DONE;
      default: state_next = B_IDLE;
    endcase
  end

  // store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pix_addr;
    ram_wdata = cmd.color;
    case (state)
      B_RUN: begin
        ram_we = in_area && !four_bit_mode;
      end
      B_RMW: begin
        ram_we    = 1'b1;
        ram_wdata = px[0] ? ({cmd.color[3:0], 4'h0} | (ram_rdata & NIB_LO))
                          : ((ram_rdata & NIB_HI) | (cmd.color & NIB_LO));
      end
      B_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = caddr[AW-1:0];
      end
      B_READ: begin
        ram_addr = AW'(cmd.roff);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tcpw_ram #(
    .WIDTH (8),
    .DEPTH (STORE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd       <= cmd_head;
          pos       <= {1'b0, cmd_head.start};
          caddr     <= '0;
          clip_acc  <= 1'b0;
          rdata_acc <= '0;
        end
      end
      B_RUN: begin
        if (!in_area) begin
          clip_acc <= 1'b1;
          pos      <= pos_inc;
        end else if (!four_bit_mode) begin
          pos <= pos_inc;
        end
      end
      B_RMW:   pos <= pos_inc;
      B_CLEAR: caddr <= caddr_inc;
      B_READ: begin
        if (!rd_in_range) begin
          clip_acc <= 1'b1;
        end
      end
      B_RDATA: rdata_acc <= ram_rdata;
      default: begin
        pos <= pos;
      end
    endcase
    if (res_load) begin
      read_data <= rdata_acc;
      clipped   <= clip_acc;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == B_RUN || state == B_RMW || state == B_CLEAR))
    else $error("store written outside a drawing state");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == B_IDLE))
    else $error("command taken while busy");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    (state == B_DONE && out_valid && !pop) |=> (state == B_DONE))
    else $error("result slot overwritten");

endmodule

`default_nettype wire

// ===== test/tiled_canvas_pixel_writer_tb.sv =====
`timescale 1ns / 1ps

module tiled_canvas_pixel_writer_tb
  import tcpw_pkg::*;
();

  localparam int STORE_BYTES  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int PHASE_ITEMS  = 133;
  // random clears only where the used store is small, to bound run time
  localparam int CLEAR_BUDGET = 4096;
  localparam int SETTLE       = 8;

  // func codes with no command behind them
  localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  stop;
    logic [7:0]  color;
    logic [15:0] offset;
  } draw_cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       clip;
  } pixel_word_t;

  typedef struct packed {
    logic       four;
    logic [5:0] tw;
    logic [4:0] th;
  } layout_t;

  // canvas image, register copy and queue of result words still owed
  class canvas_scoreboard;
    bit [7:0]     canvas [STORE_BYTES];
    bit           four_bit;
    bit [5:0]     width_reg;
    bit [4:0]     height_reg;
    int unsigned  last_touched;
    int unsigned  mismatches;
    pixel_word_t  pending_words [$];

    function new();
      four_bit     = 1'b0;
      width_reg    = RST_WIDTH_TILES;
      height_reg   = RST_HEIGHT_TILES;
      last_touched = 0;
      mismatches   = 0;
    endfunction

    function void set_register(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        CFG_FOUR_BIT: four_bit = data[0];
        CFG_WIDTH: width_reg = data[5:0];
        CFG_HEIGHT: height_reg = data[4:0];
        default: ;
      endcase
    endfunction

    // size registers saturate to the legal tile counts
    function int unsigned tiles_across();
      int unsigned t;
      t = width_reg;
      if (t < 1) t = 1;
      if (t > DEF_MAX_WIDTH / TILE) t = DEF_MAX_WIDTH / TILE;
      return t;
    endfunction

    function int unsigned tiles_down();
      int unsigned t;
      t = height_reg;
      if (t < 1) t = 1;
      if (t > DEF_MAX_HEIGHT / TILE) t = DEF_MAX_HEIGHT / TILE;
      return t;
    endfunction

    function int unsigned used_bytes();
      int unsigned n;
      n = tiles_across() * TILE * tiles_down() * TILE;
      return four_bit ? n / 2 : n;
    endfunction

    // one pixel; returns 1 when it lies outside the draw area
    function bit plot(int unsigned x, int unsigned y, logic [7:0] c);
      int unsigned tw, base, idx;
      tw = tiles_across();
      if (x >= tw * TILE || y >= tiles_down() * TILE) return 1'b1;
      base = ((x / TILE) + (y / TILE) * tw) * (TILE * TILE) + (y % TILE) * TILE;
      if (four_bit) begin
        // two pixels per byte: odd x in the high nibble
        idx = (base + x % TILE) / 2;
        if (x % 2 == 1)
          canvas[idx][7:4] = c[3:0];
        else
          canvas[idx][3:0] = c[3:0];
      end else begin
        idx = base + x % TILE;
        canvas[idx] = c;
      end
      last_touched = idx;
      return 1'b0;
    endfunction

    function void apply_command(draw_cmd_t c);
      pixel_word_t w;
      int unsigned i, n;
      bit [7:0]    fill;
      w = '0;
      case (c.func)
        FUNC_SET: w.clip = plot(c.x, c.y, c.color);
        FUNC_HLINE: begin
          for (i = c.x; i < c.stop; i++)
            if (plot(i, c.y, c.color)) w.clip = 1'b1;
        end
        FUNC_VLINE: begin
          for (i = c.y; i < c.stop; i++)
            if (plot(c.x, i, c.color)) w.clip = 1'b1;
        end
        FUNC_CLEAR: begin
          fill = four_bit ? {c.color[3:0], c.color[3:0]} : c.color;
          n = used_bytes();
          for (i = 0; i < n; i++) canvas[i] = fill;
        end
        FUNC_READ: begin
          if (c.offset < used_bytes())
            w.data = canvas[c.offset];
          else
            w.clip = 1'b1;
        end
        default: ;
      endcase
      pending_words.push_back(w);
    endfunction

    function void check_word(logic [7:0] data, logic clip);
      pixel_word_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: read_data=%h clipped=%b", data, clip);
        return;
      end
      want = pending_words.pop_front();
      if (data !== want.data || clip !== want.clip) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: read_data exp %h got %h, clipped exp %b got %b",
                   want.data, data, want.clip, clip);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [2:0]          func = '0;
  logic [7:0]          x_coord = '0;
  logic [7:0]          y_coord = '0;
  logic [7:0]          end_coord = '0;
  logic [7:0]          color = '0;
  logic [15:0]         read_offset = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [7:0]          read_data;
  logic                clipped;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_data = '0;

  canvas_scoreboard    model;
  // shared by both sides: high means neither side idles
  bit                  calm = 1'b0;

  tiled_canvas_pixel_writer dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .end_coord   (end_coord),
    .color       (color),
    .read_offset (read_offset),
    .empty       (empty),
    .pop         (pop),
    .read_data   (read_data),
    .clipped     (clipped),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic draw_cmd_t make_cmd(logic [2:0] f, logic [7:0] x, logic [7:0] y,
                                         logic [7:0] stop, logic [7:0] c,
                                         logic [15:0] off);
    draw_cmd_t d;
    d.func   = f;
    d.x      = x;
    d.y      = y;
    d.stop   = stop;
    d.color  = c;
    d.offset = off;
    return d;
  endfunction

  // mostly inside the area, sometimes anywhere in the field
  function automatic logic [7:0] pick_coord(int unsigned span);
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return 8'($urandom_range(0, span - 1));
  endfunction

  // short runs mostly; a random end also gives empty and long runs
  function automatic logic [7:0] pick_stop(logic [7:0] start);
    int unsigned s;
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    s = start + $urandom_range(0, 12);
    return (s > 255) ? 8'd255 : 8'(s);
  endfunction

  function automatic draw_cmd_t random_command();
    draw_cmd_t   c;
    int unsigned wpx, hpx, used, pick;
    wpx = model.tiles_across() * TILE;
    hpx = model.tiles_down() * TILE;
    used = model.used_bytes();
    c.x = pick_coord(wpx);
    c.y = pick_coord(hpx);
    c.stop = 8'($urandom);
    c.color = 8'($urandom);
    c.offset = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      c.func = FUNC_SET;
    end else if (pick < 48) begin
      c.func = FUNC_HLINE;
      c.stop = pick_stop(c.x);
    end else if (pick < 66) begin
      c.func = FUNC_VLINE;
      c.stop = pick_stop(c.y);
    end else if (pick < 88) begin
      c.func = FUNC_READ;
      case ($urandom_range(0, 9))
        0: ;
        1: c.offset = 16'(used - 2 + $urandom_range(0, 3));
        2, 3, 4, 5: c.offset = 16'(model.last_touched);
        default: c.offset = 16'($urandom_range(0, used - 1));
      endcase
    end else if (pick < 92) begin
      c.func = FUNC_CLEAR;
    end else if (pick < 96) begin
      c.func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
    end else begin
      // noise: any code with unrelated fields
      c.func = 3'($urandom);
    end
    if (c.func == FUNC_CLEAR && used > CLEAR_BUDGET) c.func = FUNC_SET;
    return c;
  endfunction

  // push one command word; entered and left at a falling edge
  task automatic send_cmd(draw_cmd_t c);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) calm = ~calm;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func        = c.func;
    x_coord     = c.x;
    y_coord     = c.y;
    end_coord   = c.stop;
    color       = c.color;
    read_offset = c.offset;
    push        = 1'b1;
    do @(posedge clk); while (full);
    model.apply_command(c);
    @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_register(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    model.set_register(idx, data);
    @(negedge clk);
  endtask

  task automatic load_layout(layout_t l);
    push = 1'b0;
    // registers change only with the block idle
    do @(negedge clk); while (model.pending_words.size() != 0);
    repeat (SETTLE) @(negedge clk);
    write_register(CFG_FOUR_BIT, CFG_DW'(l.four));
    write_register(CFG_WIDTH, l.tw);
    write_register(CFG_HEIGHT, CFG_DW'(l.th));
    cfg_valid = 1'b0;
  endtask

  // stimulus: directed words, then random phases over several layouts
  initial begin : stimulus
    layout_t     layouts [10];
    int unsigned n;
    layouts = '{
      {1'b0, 6'd1,  5'd1},
      {1'b1, 6'd0,  5'd0},
      {1'b0, 6'd4,  5'd3},
      {1'b1, 6'd2,  5'd5},
      {1'b0, 6'd63, 5'd31},
      {1'b1, 6'd7,  5'd1},
      {1'b0, 6'd0,  5'd24},
      {1'b1, 6'd1,  5'd31},
      {1'b0, 6'd31, 5'd2},
      {1'b1, 6'd32, 5'd24}
    };
    model = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // full-size 8-bit canvas; the first clear defines every store byte
    send_cmd(make_cmd(FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'hA5, 16'd0));
    send_cmd(make_cmd(FUNC_SET, 8'd0, 8'd0, 8'd0, 8'hFF, 16'd0));
    send_cmd(make_cmd(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0));
    // bottom-right corner pixel lands on the last byte
    send_cmd(make_cmd(FUNC_SET, 8'd255, 8'd191, 8'd0, 8'h00, 16'd0));
    send_cmd(make_cmd(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'd49151));
    send_cmd(make_cmd(FUNC_SET, 8'd0, 8'd192, 8'd0, 8'h11, 16'd0));
    send_cmd(make_cmd(FUNC_SET, 8'd255, 8'd255, 8'd0, 8'h22, 16'hFFFF));
    send_cmd(make_cmd(FUNC_HLINE, 8'd250, 8'd5, 8'd255, 8'h3C, 16'd0));
    // empty runs: end equal to and below the start
    send_cmd(make_cmd(FUNC_HLINE, 8'd10, 8'd6, 8'd10, 8'h44, 16'd0));
    send_cmd(make_cmd(FUNC_VLINE, 8'd20, 8'd6, 8'd3, 8'h55, 16'd0));
    // run leaving the area at the bottom
    send_cmd(make_cmd(FUNC_VLINE, 8'd7, 8'd180, 8'd255, 8'h81, 16'd0));
    send_cmd(make_cmd(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'd47159));
    send_cmd(make_cmd(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'd49152));
    send_cmd(make_cmd(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF));
    send_cmd(make_cmd(FUNC_SPARE_FIRST, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 16'($urandom)));
    send_cmd(make_cmd(FUNC_SPARE_LAST, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 16'($urandom)));
    send_cmd(make_cmd(FUNC_HLINE, 8'd0, 8'd100, 8'd255, 8'h5A, 16'd0));

    // 4-bit mode with oversized tile counts, two nibbles of one byte
    load_layout({1'b1, 6'd63, 5'd31});
    send_cmd(make_cmd(FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'h7E, 16'd0));
    send_cmd(make_cmd(FUNC_SET, 8'd4, 8'd2, 8'd0, 8'hF3, 16'd0));
    send_cmd(make_cmd(FUNC_SET, 8'd5, 8'd2, 8'd0, 8'h0C, 16'd0));
    send_cmd(make_cmd(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'd10));
    send_cmd(make_cmd(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'd24575));
    send_cmd(make_cmd(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'd24576));

    foreach (layouts[p]) begin
      load_layout(layouts[p]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // mid-phase hold-off until every owed word is back
        if (n == PHASE_ITEMS / 2) begin
          push = 1'b0;
          do @(negedge clk); while (model.pending_words.size() != 0);
        end
        send_cmd(random_command());
      end
    end

    push = 1'b0;
    do @(negedge clk); while (model.pending_words.size() != 0);
    repeat (20) @(negedge clk);
    if (model.mismatches == 0 && model.pending_words.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // result side: pop with random stalls and check each word taken
  initial begin : drain
    int unsigned gap;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      model.check_word(read_data, clipped);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
